### src/soa_pkg.sv
// Shared types, codes and sizes of the slab object allocator.
package soa_pkg;

  localparam int NUM_SLABS  = 16;
  localparam int SLAB_W     = 4;
  localparam int OBJ_W      = 8;
  localparam int MEM_DEPTH  = 4096;
  localparam int MEM_AW     = SLAB_W + OBJ_W;

  localparam logic [4:0] SLAB_NIL = 5'd16;
  localparam logic [8:0] OBJ_NIL  = 9'd256;
  localparam logic [8:0] OBJ_MAX  = 9'd256;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_SHRINK = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  localparam logic [1:0] LIST_EMPTY   = 2'd0;
  localparam logic [1:0] LIST_PARTIAL = 2'd1;
  localparam logic [1:0] LIST_FULL    = 2'd2;

  localparam logic REG_OBJ_BYTES        = 1'b0;
  localparam logic REG_OBJECTS_PER_SLAB = 1'b1;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] slab_index;
    logic [7:0] object_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  alloc_slab_index;
    logic [7:0]  alloc_object_index;
    logic [21:0] byte_offset;
    logic [4:0]  released_count;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_A_MOVE, S_OPEN, S_OPEN_FIN, S_A_POP, S_A_UPD, S_F_CHK,
    S_UL_HEAD, S_UL_WALK, S_PUSH, S_SHRINK, S_FINISH
  } state_t;

endpackage

### src/slab_object_allocator_unit.sv
// Top level of the slab object allocator: sequencer, slab tables and object memory.
//
//  Channel   Signals                          Handshake
//  command   start, request (cmd_t), busy     taken when start && !busy
//  result    done, result (result_t)          one cycle, cannot be held off
//  config    APB psel..prdata, pready         written at psel&penable&pwrite
//
// Allocation from the partial list pops the slab's free head and updates it; a slab
// from the empty list is first moved onto the partial list, and a slab that fills is
// unlinked and pushed onto the full list. Opening a fresh slab sweeps its object links,
// one memory write a cycle, over the clamped objects_per_slab. Freeing links the object
// back; a slab that changes list is unlinked and pushed, and unlinking a slab from the
// middle of a list walks it one slab a cycle, up to 16 steps. Shrink walks the empty
// list one slab a cycle and releases each slab on it.
// Reset clears state, done, in-use bits and the three list heads; config gets defaults.
// The result receiver cannot stall; busy falls in the cycle of the result strobe.
module slab_object_allocator_unit
  import soa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cmd_t        request,
  output logic        busy,
  output logic        done,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t state, state_next;

  logic [22:0] obj_bytes;
  logic [8:0]  objects_per_slab;
  logic [8:0]  eff;

  logic [NUM_SLABS-1:0] in_use;
  logic [4:0] list_next [NUM_SLABS];
  logic [8:0] used      [NUM_SLABS];
  logic [8:0] free_head [NUM_SLABS];
  logic [4:0] heads     [3];

  logic [8:0] obj_mem [MEM_DEPTH];
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [8:0]        mem_wdata, mem_rdata;

  logic [4:0] sp;
  logic [3:0] sp_idx;
  logic [3:0] s;
  logic [7:0] obj;
  logic [8:0] n_open;
  logic [7:0] ctr;
  logic [4:0] k;
  logic [4:0] count;
  logic [4:0] next_s;
  logic [1:0] ul_list, push_list;
  result_t    res_q;
  result_t    res_init;

  logic        any_free;
  logic [3:0]  low_free;
  logic        sweep_last;
  logic [8:0]  fh;
  logic        bad_free;
  logic [8:0]  used_dec;
  logic        walk_end;
  logic [30:0] prod;

  assign sp_idx = sp[3:0];
  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;

  always_comb begin
    if (objects_per_slab == 9'd0) begin
      eff = 9'd1;
    end else if (objects_per_slab > OBJ_MAX) begin
      eff = OBJ_MAX;
    end else begin
      eff = objects_per_slab;
    end
  end

  // Lowest slab slot not in use.
  always_comb begin
    any_free = 1'b0;
    low_free = '0;
    for (int i = NUM_SLABS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        any_free = 1'b1;
        low_free = 4'(i);
      end
    end
  end

  // An allocation with no list to take from and no free slot fails at once.
  always_comb begin
    res_init = '0;
    if (request.operation == OP_ALLOC && heads[LIST_PARTIAL][4] && heads[LIST_EMPTY][4]
        && !any_free) begin
      res_init.status = ST_NO_SLOT;
    end
  end

  assign sweep_last = ({1'b0, ctr} + 9'd1) == n_open;
  assign fh         = free_head[sp_idx];
  assign used_dec   = used[sp_idx] - 9'd1;
  assign bad_free   = !in_use[s] || ({1'b0, obj} >= eff) || (used[sp_idx] == 9'd0);
  assign walk_end   = (k == 5'd16) || sp[4];
  assign prod       = 31'(obj) * 31'(obj_bytes);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (request.operation)
            OP_ALLOC: begin
              if (!heads[LIST_PARTIAL][4]) begin
                state_next = S_A_POP;
              end else if (!heads[LIST_EMPTY][4]) begin
                state_next = S_A_MOVE;
              end else if (any_free) begin
                state_next = S_OPEN;
              end else begin
                state_next = S_FINISH;
              end
            end
            OP_FREE:   state_next = S_F_CHK;
            OP_SHRINK: state_next = S_SHRINK;
            default:   state_next = S_FINISH;
          endcase
        end
      end
      S_A_MOVE: state_next = S_A_POP;
      S_OPEN: begin
        if (sweep_last) begin
          state_next = S_OPEN_FIN;
        end
      end
      S_OPEN_FIN: state_next = S_A_POP;
      S_A_POP: state_next = fh[8] ? S_FINISH : S_A_UPD;
      S_A_UPD: state_next = mem_rdata[8] ? S_UL_HEAD : S_FINISH;
      S_F_CHK: begin
        if (bad_free) begin
          state_next = S_FINISH;
        end else if (fh[8] || used_dec == 9'd0) begin
          state_next = S_UL_HEAD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_UL_HEAD: state_next = (heads[ul_list] == {1'b0, s}) ? S_PUSH : S_UL_WALK;
      S_UL_WALK: begin
        if (walk_end || list_next[sp_idx] == {1'b0, s}) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: state_next = S_FINISH;
      S_SHRINK: begin
        if (walk_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Object memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {s, ctr};
    mem_wdata = sweep_last ? OBJ_NIL : ({1'b0, ctr} + 9'd1);
    mem_raddr = {s, fh[7:0]};
    case (state)
      S_OPEN: mem_we = 1'b1;
      S_F_CHK: begin
        mem_we    = !bad_free;
        mem_waddr = {s, obj};
        mem_wdata = fh;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      obj_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= obj_mem[mem_raddr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      obj_bytes        <= 23'd64;
      objects_per_slab <= 9'd256;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_OBJ_BYTES:        obj_bytes        <= pwdata[22:0];
        REG_OBJECTS_PER_SLAB: objects_per_slab <= pwdata[8:0];
        default:              obj_bytes        <= obj_bytes;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OBJ_BYTES:        prdata = {9'd0, obj_bytes};
      REG_OBJECTS_PER_SLAB: prdata = {23'd0, objects_per_slab};
      default:              prdata = '0;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      in_use <= '0;
      for (int i = 0; i < 3; i++) begin
        heads[i] <= SLAB_NIL;
      end
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);
      case (state)
        S_A_MOVE: begin
          heads[LIST_EMPTY]   <= list_next[sp_idx];
          heads[LIST_PARTIAL] <= {1'b0, s};
        end
        S_OPEN_FIN: begin
          in_use[s]           <= 1'b1;
          heads[LIST_PARTIAL] <= {1'b0, s};
        end
        S_UL_HEAD: begin
          if (heads[ul_list] == {1'b0, s}) begin
            heads[ul_list] <= next_s;
          end
        end
        S_PUSH: heads[push_list] <= {1'b0, s};
        S_SHRINK: begin
          if (walk_end) begin
            heads[LIST_EMPTY] <= SLAB_NIL;
          end else begin
            in_use[sp_idx] <= 1'b0;
          end
        end
        default: in_use <= in_use;
      endcase
    end
  end

  // Slab tables and working registers.
  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      result <= res_q;
    end
    case (state)
      S_IDLE: begin
        res_q <= res_init;
        k     <= '0;
        count <= '0;
        ctr   <= '0;
        n_open <= eff;
        obj   <= request.object_index;
        if (request.operation == OP_ALLOC) begin
          if (!heads[LIST_PARTIAL][4]) begin
            s  <= heads[LIST_PARTIAL][3:0];
            sp <= heads[LIST_PARTIAL];
          end else if (!heads[LIST_EMPTY][4]) begin
            s  <= heads[LIST_EMPTY][3:0];
            sp <= heads[LIST_EMPTY];
          end else begin
            s  <= low_free;
            sp <= {1'b0, low_free};
          end
        end else if (request.operation == OP_FREE) begin
          s  <= request.slab_index;
          sp <= {1'b0, request.slab_index};
        end else begin
          sp <= heads[LIST_EMPTY];
        end
      end
      S_A_MOVE: list_next[s] <= heads[LIST_PARTIAL];
      S_OPEN: ctr <= ctr + 8'd1;
      S_OPEN_FIN: begin
        free_head[s] <= 9'd0;
        used[s]      <= 9'd0;
        list_next[s] <= heads[LIST_PARTIAL];
        sp           <= {1'b0, s};
      end
      S_A_POP: begin
        obj <= fh[7:0];
        if (fh[8]) begin
          res_q.status <= ST_NO_SLOT;
        end
      end
      S_A_UPD: begin
        free_head[s]             <= mem_rdata;
        used[s]                  <= used[sp_idx] + 9'd1;
        res_q.alloc_slab_index   <= s;
        res_q.alloc_object_index <= obj;
        res_q.byte_offset        <= prod[21:0];
        next_s                   <= list_next[sp_idx];
        ul_list                  <= LIST_PARTIAL;
        push_list                <= LIST_FULL;
      end
      S_F_CHK: begin
        next_s <= list_next[sp_idx];
        if (bad_free) begin
          res_q.status <= ST_BAD_FREE;
        end else begin
          free_head[s] <= {1'b0, obj};
          used[s]      <= used_dec;
          if (fh[8]) begin
            ul_list   <= LIST_FULL;
            push_list <= (used_dec != 9'd0) ? LIST_PARTIAL : LIST_EMPTY;
          end else begin
            ul_list   <= LIST_PARTIAL;
            push_list <= LIST_EMPTY;
          end
        end
      end
      S_UL_HEAD: begin
        sp <= heads[ul_list];
        k  <= '0;
      end
      S_UL_WALK: begin
        if (!walk_end) begin
          if (list_next[sp_idx] == {1'b0, s}) begin
            list_next[sp_idx] <= next_s;
          end else begin
            sp <= list_next[sp_idx];
            k  <= k + 5'd1;
          end
        end
      end
      S_PUSH: list_next[s] <= heads[push_list];
      S_SHRINK: begin
        if (walk_end) begin
          res_q.released_count <= count;
        end else begin
          count <= count + 5'd1;
          sp    <= list_next[sp_idx];
          k     <= k + 5'd1;
        end
      end
      default: k <= k;
    endcase
  end

  a_finish_strobes: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH |=> done)
    else $error("result strobe missing after finish");

  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    state == S_OPEN |-> ({1'b0, ctr} < n_open))
    else $error("link sweep ran past the slab");

  a_pop_before_update: assert property (@(posedge clk) disable iff (rst)
    state == S_A_UPD |-> $past(state) == S_A_POP)
    else $error("memory read data used without a read");

  a_partial_full_apart: assert property (@(posedge clk) disable iff (rst)
    !heads[LIST_PARTIAL][4] |-> heads[LIST_PARTIAL] != heads[LIST_FULL])
    else $error("one slab heads both partial and full lists");

  a_empty_partial_apart: assert property (@(posedge clk) disable iff (rst)
    !heads[LIST_EMPTY][4] |-> heads[LIST_EMPTY] != heads[LIST_PARTIAL])
    else $error("one slab heads both empty and partial lists");

endmodule

### bench/slab_object_allocator_unit_tb.sv
// Self-checking testbench for the slab object allocator: directed and random commands.
`timescale 1ns / 100ps

import soa_pkg::*;

class slab_scoreboard;
  // Predicted allocator state
  bit          in_use [NUM_SLABS];
  logic [4:0]  next_slab [NUM_SLABS];
  logic [8:0]  used_cnt [NUM_SLABS];
  logic [8:0]  free_head [NUM_SLABS];
  logic [8:0]  obj_link [MEM_DEPTH];
  logic [4:0]  heads [3];
  logic [22:0] obj_bytes;
  logic [8:0]  obj_per_slab;

  result_t     pending [$];
  int          mismatches;
  int          n_alloc_ok, n_no_slot, n_bad_free, n_free_ok, n_shrink, n_released;

  function new();
    obj_bytes    = 23'd64;
    obj_per_slab = 9'd256;
    foreach (in_use[i]) in_use[i] = 1'b0;
    foreach (heads[i]) heads[i] = SLAB_NIL;
    mismatches = 0;
  endfunction

  function int eff_count();
    int n;
    n = obj_per_slab;
    if (n < 1) n = 1;
    if (n > OBJ_MAX) n = OBJ_MAX;
    return n;
  endfunction

  function void push_list(logic [1:0] lst, int s);
    next_slab[s] = heads[lst];
    heads[lst]   = s[4:0];
  endfunction

  function void unlink(logic [1:0] lst, int s);
    int p;
    p = heads[lst];
    if (p == s) begin
      heads[lst] = next_slab[s];
      return;
    end
    for (int k = 0; k < NUM_SLABS; k++) begin
      if (p >= NUM_SLABS) return;
      if (next_slab[p] == s) begin
        next_slab[p] = next_slab[s];
        return;
      end
      p = next_slab[p];
    end
  endfunction

  // Works out the result of an accepted item and queues it.
  function result_t note(cmd_t c);
    result_t r;
    int s, obj, n;
    bit was_full;
    longint unsigned prod;
    r = '0;
    case (c.operation)
      OP_ALLOC: begin
        s = heads[LIST_PARTIAL];
        if (s >= NUM_SLABS) begin
          s = heads[LIST_EMPTY];
          if (s < NUM_SLABS) begin
            unlink(LIST_EMPTY, s);
            push_list(LIST_PARTIAL, s);
          end else begin
            for (s = 0; s < NUM_SLABS; s++)
              if (!in_use[s]) break;
            if (s < NUM_SLABS) begin
              n = eff_count();
              for (int i = 0; i < n - 1; i++) obj_link[s * 256 + i] = i + 1;
              obj_link[s * 256 + n - 1] = OBJ_NIL;
              free_head[s] = '0;
              used_cnt[s]  = '0;
              in_use[s]    = 1'b1;
              push_list(LIST_PARTIAL, s);
            end
          end
        end
        if (s >= NUM_SLABS || free_head[s] >= OBJ_MAX) begin
          r.status = ST_NO_SLOT;
          n_no_slot++;
        end else begin
          obj          = free_head[s];
          free_head[s] = obj_link[s * 256 + obj];
          used_cnt[s]  = used_cnt[s] + 9'd1;
          if (free_head[s] >= OBJ_MAX) begin
            unlink(LIST_PARTIAL, s);
            push_list(LIST_FULL, s);
          end
          prod = longint'(obj) * longint'(obj_bytes);
          r.alloc_slab_index   = s[3:0];
          r.alloc_object_index = obj[7:0];
          r.byte_offset        = prod[21:0];
          n_alloc_ok++;
        end
      end
      OP_FREE: begin
        s   = c.slab_index;
        obj = c.object_index;
        if (!in_use[s] || obj >= eff_count() || used_cnt[s] == 0) begin
          r.status = ST_BAD_FREE;
          n_bad_free++;
        end else begin
          was_full = free_head[s] >= OBJ_MAX;
          obj_link[s * 256 + obj] = free_head[s];
          free_head[s] = obj[8:0];
          used_cnt[s]  = used_cnt[s] - 9'd1;
          if (was_full) begin
            unlink(LIST_FULL, s);
            push_list((used_cnt[s] != 0) ? LIST_PARTIAL : LIST_EMPTY, s);
          end else if (used_cnt[s] == 0) begin
            unlink(LIST_PARTIAL, s);
            push_list(LIST_EMPTY, s);
          end
          n_free_ok++;
        end
      end
      OP_SHRINK: begin
        s = heads[LIST_EMPTY];
        n = 0;
        for (int k = 0; k < NUM_SLABS; k++) begin
          if (s >= NUM_SLABS) break;
          in_use[s] = 1'b0;
          n++;
          s = next_slab[s];
        end
        heads[LIST_EMPTY] = SLAB_NIL;
        r.released_count  = n[4:0];
        n_shrink++;
        n_released += n;
      end
      default: ;
    endcase
    pending.push_back(r);
    return r;
  endfunction

  function void check(result_t got);
    result_t exp_r;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("ERROR: unexpected result %p", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got.status !== exp_r.status || got.alloc_slab_index !== exp_r.alloc_slab_index ||
        got.alloc_object_index !== exp_r.alloc_object_index ||
        got.byte_offset !== exp_r.byte_offset ||
        got.released_count !== exp_r.released_count) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR at %0t: expected %p, got %p", $realtime, exp_r, got);
    end
  endfunction
endclass

module slab_object_allocator_unit_tb;
  logic        clk;
  logic        rst;
  logic        start;
  cmd_t        request;
  logic        busy;
  logic        done;
  result_t     result;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  slab_scoreboard sb;
  int  cycles;
  bit  calm;        // no idle gaps while set
  logic [11:0] held [$];   // {slab, object} of objects believed allocated

  localparam int CYCLE_LIMIT = 1500000;
  localparam logic [2:0] ADDR_OBJ_BYTES        = 3'd0;
  localparam logic [2:0] ADDR_OBJECTS_PER_SLAB = 3'd4;

  slab_object_allocator_unit dut (
    .clk, .rst, .start, .request, .busy, .done, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && done) sb.check(result);

  task automatic reg_write(logic [2:0] addr, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == ADDR_OBJ_BYTES) sb.obj_bytes = value[22:0];
    else sb.obj_per_slab = value[8:0];
  endtask

  // Stops issuing, waits for every outstanding result, then sets both registers.
  task automatic configure(int size, int count);
    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    reg_write(ADDR_OBJ_BYTES, size);
    reg_write(ADDR_OBJECTS_PER_SLAB, count);
  endtask

  task automatic issue(logic [1:0] op, logic [3:0] slab, logic [7:0] obj);
    cmd_t c;
    result_t r;
    c.operation = op; c.slab_index = slab; c.object_index = obj;
    @(negedge clk);
    start = 1'b1;
    request = c;
    do @(posedge clk); while (busy);
    r = sb.note(c);
    if (op == OP_ALLOC && r.status == ST_OK) held.push_back({r.alloc_slab_index,
                                                             r.alloc_object_index});
    if (!calm && $urandom_range(99) < 34) begin
      @(negedge clk);
      start = 1'b0;
      request = cmd_t'($urandom);
      repeat ($urandom_range(4)) @(negedge clk);
    end
  endtask

  task automatic free_held(bit keep);
    int i;
    logic [11:0] h;
    if (held.size() == 0) begin
      issue(OP_FREE, 4'($urandom), 8'($urandom));
      return;
    end
    i = $urandom_range(held.size() - 1);
    h = held[i];
    if (!keep) held.delete(i);
    issue(OP_FREE, h[11:8], h[7:0]);
  endtask

  task automatic random_items(int count);
    int p;
    for (int k = 0; k < count; k++) begin
      calm = (k >= count / 3 && k < count / 3 + 60);
      p = $urandom_range(99);
      if (p < 50 - (held.size() > 300 ? 25 : 0)) issue(OP_ALLOC, 4'($urandom), 8'($urandom));
      else if (p < 85) free_held(1'b0);
      else if (p < 87) free_held(1'b1);               // double free
      else if (p < 93) issue(OP_FREE, 4'($urandom), 8'($urandom));
      else if (p < 98) issue(OP_SHRINK, 4'($urandom), 8'($urandom));
      else issue(OP_UNUSED, 4'($urandom), 8'($urandom));
    end
    calm = 1'b0;
  endtask

  initial begin
    int waited;
    sb = new();
    cycles = 0;
    calm = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: defaults, bad frees, double free, shrink, unused operation code
    issue(OP_SHRINK, 4'd0, 8'd0);
    issue(OP_FREE, 4'd0, 8'd0);
    issue(OP_ALLOC, 4'd0, 8'd0);
    issue(OP_ALLOC, 4'd15, 8'd255);
    issue(OP_FREE, 4'd0, 8'd255);
    issue(OP_FREE, 4'd15, 8'd0);
    issue(OP_FREE, 4'd0, 8'd1);
    issue(OP_FREE, 4'd0, 8'd1);
    issue(OP_FREE, 4'd0, 8'd0);
    issue(OP_FREE, 4'd0, 8'd0);
    issue(OP_SHRINK, 4'd15, 8'd255);
    issue(OP_UNUSED, 4'd15, 8'd255);
    held.delete();
    // One object per slab: every allocation fills a slab, so the pool runs out
    configure(4194304, 1);
    repeat (17) issue(OP_ALLOC, 4'd0, 8'd0);
    issue(OP_FREE, 4'd3, 8'd0);
    issue(OP_FREE, 4'd3, 8'd1);
    issue(OP_SHRINK, 4'd0, 8'd0);
    issue(OP_ALLOC, 4'd0, 8'd0);

    configure(4194304, 1);   random_items(200);
    configure(8, 256);       random_items(300);
    configure(100, 7);       random_items(300);
    configure(4194304, 4);   random_items(250);
    configure(24, 2);        random_items(250);   // lowered while slabs are open
    configure(1 + $urandom_range(4194303), 1 + $urandom_range(255));
    random_items(200);
    configure(64, 256);      random_items(200);

    @(negedge clk);
    start = 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    $display("Covered %0d good and %0d failed allocations, %0d good and %0d bad frees,",
             sb.n_alloc_ok, sb.n_no_slot, sb.n_free_ok, sb.n_bad_free);
    $display("and %0d shrinks releasing %0d slabs; %0d mismatches.",
             sb.n_shrink, sb.n_released, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (sb.pending.size() != 0) $display("ERROR: %0d results never arrived",
                                           sb.pending.size());
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
